// ----- design/swd_mem_ap_transfer_engine_top_macros.svh -----
// Assertion macros for the SWD MEM-AP transfer engine.
// Included by the top level; depends on nothing else.
`ifndef SWD_MEM_AP_TRANSFER_ENGINE_TOP_MACROS_SVH
`define SWD_MEM_AP_TRANSFER_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWDAP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swdap check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWDAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swdap check failed");

`endif

// ----- design/swdap_pkg.sv -----
// Shared types, codes and the phase walk for the SWD MEM-AP transfer engine.
// Used by the result queue and the top level; depends on nothing.
package swdap_pkg;

  localparam int WAIT_RETRY_LIMIT = 100;
  localparam int TAR_WRAP_BYTES   = 1024;
  localparam int RETRY_W          = 8;
  localparam int CHUNK_W          = 11;
  localparam int RQ_DEPTH         = 4;

  localparam logic [31:0] SHADOW_INVALID = 32'hFFFF_FFFF;
  localparam logic [31:0] ABORT_CLEAR    = 32'h0000_001E;
  localparam logic [31:0] ABORT_DAP      = 32'h0000_0001;
  localparam logic [31:0] CTRL_ERR_MASK  = 32'h0000_00A0;
  localparam logic [31:0] CSW_BLOCK_BITS = 32'h0000_0012;

  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_WORD  = 2'd1;
  localparam logic [1:0] OP_RESP  = 2'd2;
  localparam logic [1:0] OP_INVAL = 2'd3;

  localparam logic [2:0] ACC_SREAD  = 3'd0;
  localparam logic [2:0] ACC_SWRITE = 3'd1;
  localparam logic [2:0] ACC_BREAD  = 3'd2;
  localparam logic [2:0] ACC_BWRITE = 3'd3;
  localparam logic [2:0] ACC_FILL   = 3'd4;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  localparam logic [2:0] ACK_OK    = 3'd1;
  localparam logic [2:0] ACK_WAIT  = 3'd2;
  localparam logic [2:0] ACK_FAULT = 3'd4;
  localparam logic [2:0] ACK_NONE  = 3'd7;

  localparam logic [1:0] KIND_PKT  = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_FAULT  = 3'd2;
  localparam logic [2:0] ST_PARITY = 3'd3;
  localparam logic [2:0] ST_NORESP = 3'd4;
  localparam logic [2:0] ST_PROTO  = 3'd5;

  localparam logic [1:0] DP_ABORT  = 2'd0;
  localparam logic [1:0] DP_CTRL   = 2'd1;
  localparam logic [1:0] DP_SELECT = 2'd2;
  localparam logic [1:0] DP_RDBUFF = 2'd3;
  localparam logic [1:0] AP_CSW    = 2'd0;
  localparam logic [1:0] AP_TAR    = 2'd1;
  localparam logic [1:0] AP_DRW    = 2'd3;

  typedef enum logic [16:0] {
    PH_IDLE      = 17'b00000000000000001,
    PH_CSW_SEL   = 17'b00000000000000010,
    PH_CSW       = 17'b00000000000000100,
    PH_TAR_SEL   = 17'b00000000000001000,
    PH_TAR       = 17'b00000000000010000,
    PH_DRW_SEL   = 17'b00000000000100000,
    PH_DUMMY     = 17'b00000000001000000,
    PH_RDBUF     = 17'b00000000010000000,
    PH_BREAD     = 17'b00000000100000000,
    PH_BRDBUF    = 17'b00000001000000000,
    PH_SWRITE    = 17'b00000010000000000,
    PH_WORD_WAIT = 17'b00000100000000000,
    PH_BWRITE    = 17'b00001000000000000,
    PH_CTRL      = 17'b00010000000000000,
    PH_FWRITE    = 17'b00100000000000000,
    PH_ABORT     = 17'b01000000000000000,
    PH_CHUNK     = 17'b10000000000000000
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SEND = 2'd1,
    ACT_FIN  = 2'd2
  } act_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ap;
    logic        rnw;
    logic [1:0]  off;
    logic [31:0] pdata;
    logic [31:0] rword;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        ap;
    logic        rnw;
    logic [1:0]  off;
    logic [31:0] data;
  } pkt_t;

  typedef struct packed {
    phase_t             ph;
    logic [CHUNK_W-1:0] chunk;
    act_t               act;
    pkt_t               pkt;
    logic [2:0]         status;
  } walk_t;

  function automatic res_t mk_pkt(pkt_t p);
    res_t r;
    r        = '0;
    r.kind   = KIND_PKT;
    r.ap     = p.ap;
    r.rnw    = p.rnw;
    r.off    = p.off;
    r.pdata  = p.rnw ? 32'd0 : p.data;
    return r;
  endfunction

  function automatic res_t mk_word(logic [31:0] v);
    res_t r;
    r       = '0;
    r.kind  = KIND_WORD;
    r.rword = v;
    return r;
  endfunction

  function automatic res_t mk_done(logic [2:0] st);
    res_t r;
    r        = '0;
    r.kind   = KIND_DONE;
    r.status = st;
    return r;
  endfunction

  function automatic pkt_t pkt(logic ap, logic rnw, logic [1:0] off, logic [31:0] d);
    pkt_t p;
    p.ap   = ap;
    p.rnw  = rnw;
    p.off  = off;
    p.data = d;
    return p;
  endfunction

  // Walks through the phases that issue no packet until one sends, waits or finishes.
  function automatic walk_t walk(phase_t start, logic [2:0] acc, logic [1:0] size,
                                 logic [31:0] ldata, logic [31:0] addr,
                                 logic [15:0] words, logic [CHUNK_W-1:0] chunk,
                                 logic [CHUNK_W-1:0] room, logic sel_eq, logic csw_eq,
                                 logic [31:0] selv, logic [31:0] cswv);
    walk_t       r;
    phase_t      ph;
    logic        done;
    logic [31:0] d;
    r      = '0;
    r.act  = ACT_NONE;
    r.chunk = chunk;
    ph     = start;
    done   = 1'b0;
    d      = ldata;
    for (int i = 0; i < 6; i++) begin
      if (!done) begin
        case (ph)
          PH_CSW_SEL: begin
            if (csw_eq) begin
              ph = (acc == ACC_FILL) ? PH_CHUNK : PH_TAR_SEL;
            end else if (sel_eq) begin
              ph = PH_CSW;
            end else begin
              r.act = ACT_SEND; r.pkt = pkt(1'b0, 1'b0, DP_SELECT, selv); done = 1'b1;
            end
          end
          PH_CSW: begin
            r.act = ACT_SEND; r.pkt = pkt(1'b1, 1'b0, AP_CSW, cswv); done = 1'b1;
          end
          PH_TAR_SEL: begin
            if (sel_eq) begin
              ph = PH_TAR;
            end else begin
              r.act = ACT_SEND; r.pkt = pkt(1'b0, 1'b0, DP_SELECT, selv); done = 1'b1;
            end
          end
          PH_TAR: begin
            r.act = ACT_SEND; r.pkt = pkt(1'b1, 1'b0, AP_TAR, addr); done = 1'b1;
          end
          PH_DRW_SEL: begin
            if (!sel_eq) begin
              r.act = ACT_SEND; r.pkt = pkt(1'b0, 1'b0, DP_SELECT, selv); done = 1'b1;
            end else if (acc == ACC_SREAD || acc == ACC_BREAD) begin
              ph = PH_DUMMY;
            end else if (acc == ACC_SWRITE) begin
              ph = PH_SWRITE;
            end else if (acc == ACC_BWRITE) begin
              ph = PH_WORD_WAIT;
            end else begin
              ph = PH_FWRITE;
            end
          end
          PH_DUMMY, PH_BREAD: begin
            r.act = ACT_SEND; r.pkt = pkt(1'b1, 1'b1, AP_DRW, 32'd0); done = 1'b1;
          end
          PH_RDBUF, PH_BRDBUF: begin
            r.act = ACT_SEND; r.pkt = pkt(1'b0, 1'b1, DP_RDBUFF, 32'd0); done = 1'b1;
          end
          PH_SWRITE: begin
            if (size == SZ_BYTE) begin
              d = {24'd0, ldata[7:0]} << {addr[1:0], 3'b000};
            end else if (size == SZ_HALF) begin
              d = {16'd0, ldata[15:0]} << {addr[1], 4'b0000};
            end
            r.act = ACT_SEND; r.pkt = pkt(1'b1, 1'b0, AP_DRW, d); done = 1'b1;
          end
          PH_WORD_WAIT: begin
            done = 1'b1;
          end
          PH_CTRL: begin
            r.act = ACT_SEND; r.pkt = pkt(1'b0, 1'b1, DP_CTRL, 32'd0); done = 1'b1;
          end
          PH_FWRITE: begin
            r.act = ACT_SEND; r.pkt = pkt(1'b1, 1'b0, AP_DRW, ldata); done = 1'b1;
          end
          PH_CHUNK: begin
            if (words == 16'd0) begin
              r.act = ACT_FIN; r.status = ST_OK; done = 1'b1;
            end else begin
              r.chunk = ({5'd0, room} > words) ? words[CHUNK_W-1:0] : room;
              ph = (acc == ACC_FILL) ? PH_TAR_SEL : PH_CSW_SEL;
            end
          end
          default: begin
            r.act = ACT_FIN; r.status = ST_PROTO; done = 1'b1;
          end
        endcase
      end
    end
    r.ph = (r.act == ACT_FIN) ? PH_IDLE : ph;
    return r;
  endfunction

endpackage

// ----- design/swdap_resq.sv -----
// Result queue of the transfer engine: takes up to two results a cycle, gives one on each pop.
// Depends on swdap_pkg.
module swdap_resq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push0,
  input  logic             push1,
  input  swdap_pkg::res_t  d0,
  input  swdap_pkg::res_t  d1,
  input  logic             pop,
  output swdap_pkg::res_t  head,
  output logic             not_empty,
  output logic             room2
);

  localparam int PW = $clog2(swdap_pkg::RQ_DEPTH);

  swdap_pkg::res_t mem_r [swdap_pkg::RQ_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_pop;
  logic [PW-1:0]   wr1;

  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  assign room2     = (cnt_r <= (PW+1)'(swdap_pkg::RQ_DEPTH - 2));
  assign do_pop    = pop && not_empty;
  assign wr1       = push0 ? wr_r + 1'b1 : wr_r;

  always_comb begin
    wr_nxt  = wr_r + PW'(push0) + PW'(push1);
    rd_nxt  = rd_r + PW'(do_pop);
    cnt_nxt = cnt_r + (PW+1)'(push0) + (PW+1)'(push1) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push0) begin
      mem_r[wr_r] <= d0;
    end
    if (push1) begin
      mem_r[wr1] <= d1;
    end
  end

endmodule

// ----- design/swd_mem_ap_transfer_engine_top.sv -----
// Top level of the SWD MEM-AP transfer engine: command decode, phase control
// and shadows. Depends on swdap_pkg, swdap_resq and the assertion macro header.

// Each accepted item is handled in the cycle it is taken and gives at most two
// result words, which go into a four-entry result queue; in_tready is high
// while the queue has room for two, so one item a cycle is taken as long as
// results are drained. A WAIT response re-issues the packet until the retry
// limit, after which an abort is sent. There is no clearing pass after reset.
`include "swd_mem_ap_transfer_engine_top_macros.svh"

module swd_mem_ap_transfer_engine_top #(
  parameter int WAIT_RETRY_LIMIT = swdap_pkg::WAIT_RETRY_LIMIT,
  parameter int TAR_WRAP_BYTES   = swdap_pkg::TAR_WRAP_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // access, size_code, address, data, word_count, ack, read_data, parity_ok, zero pad
  input  logic [127:0] in_tdata,
  // op
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ap_not_dp, read_not_write, reg_offset, packet_data, read_word, status, zero pad
  output logic [71:0]  out_tdata,
  // kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CW = swdap_pkg::CHUNK_W;

  logic [7:0]                 ap_index_r;
  logic [31:0]                csw_base_r;
  logic [31:0]                sel_r, sel_nxt, csw_r, csw_nxt;
  swdap_pkg::phase_t          phase_r, phase_nxt;
  logic [31:0]                addr_r, addr_nxt;
  logic [15:0]                words_r, words_nxt;
  logic [CW-1:0]              chunk_r, chunk_nxt;
  logic [swdap_pkg::RETRY_W-1:0] retries_r, retries_nxt;
  swdap_pkg::pkt_t            pend_r, pend_nxt;
  logic [31:0]                ldata_r, ldata_nxt;
  logic [1:0]                 lsize_r, lsize_nxt;
  logic [2:0]                 lacc_r, lacc_nxt;
  logic [2:0]                 fstat_r, fstat_nxt;

  logic [2:0]  i_acc;
  logic [1:0]  i_size;
  logic [31:0] i_addr, i_data, i_rd;
  logic [15:0] i_words;
  logic [2:0]  i_ack;
  logic        i_par;
  logic        in_fire;

  logic                 room2;
  logic                 q_ne;
  swdap_pkg::res_t      q_head;
  swdap_pkg::res_t      dr, r0, r1;
  logic                 dr_v, en_go, push0, push1, inval;
  swdap_pkg::phase_t    en_start;
  swdap_pkg::walk_t     w;
  logic [31:0]          selv, cswv, lane, low, room32;
  logic [CW-1:0]        room;
  logic [swdap_pkg::RETRY_W-1:0] retry_inc;

  assign i_acc   = in_tdata[2:0];
  assign i_size  = in_tdata[4:3];
  assign i_addr  = in_tdata[36:5];
  assign i_data  = in_tdata[68:37];
  assign i_words = in_tdata[84:69];
  assign i_ack   = in_tdata[87:85];
  assign i_rd    = in_tdata[119:88];
  assign i_par   = in_tdata[120];

  assign in_tready = room2;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign selv      = {ap_index_r, 24'd0};
  assign retry_inc = retries_r + 1'b1;

  always_comb begin
    sel_nxt     = sel_r;
    csw_nxt     = csw_r;
    phase_nxt   = phase_r;
    addr_nxt    = addr_r;
    words_nxt   = words_r;
    chunk_nxt   = chunk_r;
    retries_nxt = retries_r;
    pend_nxt    = pend_r;
    ldata_nxt   = ldata_r;
    lsize_nxt   = lsize_r;
    lacc_nxt    = lacc_r;
    fstat_nxt   = fstat_r;
    dr          = '0;
    dr_v        = 1'b0;
    en_go       = 1'b0;
    en_start    = swdap_pkg::PH_IDLE;
    inval       = 1'b0;
    lane        = i_rd;
    if (lsize_r == swdap_pkg::SZ_BYTE) begin
      lane = {24'd0, 8'(i_rd >> {addr_r[1:0], 3'b000})};
    end else if (lsize_r == swdap_pkg::SZ_HALF) begin
      lane = {16'd0, 16'(i_rd >> {addr_r[1], 4'b0000})};
    end
    if (in_fire) begin
      unique case (in_tuser)
        swdap_pkg::OP_CMD: begin
          if (phase_r == swdap_pkg::PH_IDLE) begin
            ldata_nxt = i_data;
            lsize_nxt = i_size;
            lacc_nxt  = i_acc;
            addr_nxt  = i_addr;
            words_nxt = i_words;
            chunk_nxt = '0;
            if (i_acc > swdap_pkg::ACC_FILL ||
                (i_acc <= swdap_pkg::ACC_SWRITE && i_size == swdap_pkg::SZ_BAD) ||
                (i_acc >= swdap_pkg::ACC_BREAD && i_addr[1:0] != 2'd0)) begin
              dr_v = 1'b1; dr = swdap_pkg::mk_done(swdap_pkg::ST_PROTO);
              phase_nxt = swdap_pkg::PH_IDLE;
            end else begin
              en_go    = 1'b1;
              en_start = (i_acc <= swdap_pkg::ACC_SWRITE || i_acc == swdap_pkg::ACC_FILL) ?
                         swdap_pkg::PH_CSW_SEL : swdap_pkg::PH_CHUNK;
            end
          end
        end
        swdap_pkg::OP_WORD: begin
          if (phase_r == swdap_pkg::PH_WORD_WAIT) begin
            phase_nxt   = swdap_pkg::PH_BWRITE;
            pend_nxt    = swdap_pkg::pkt(1'b1, 1'b0, swdap_pkg::AP_DRW, i_data);
            retries_nxt = '0;
            dr_v = 1'b1; dr = swdap_pkg::mk_pkt(pend_nxt);
          end
        end
        swdap_pkg::OP_RESP: begin
          if (phase_r != swdap_pkg::PH_IDLE && phase_r != swdap_pkg::PH_WORD_WAIT) begin
            if (phase_r == swdap_pkg::PH_ABORT) begin
              dr_v = 1'b1; dr = swdap_pkg::mk_done(fstat_r);
              phase_nxt = swdap_pkg::PH_IDLE;
            end else if (i_ack == swdap_pkg::ACK_OK && pend_r.rnw && !i_par) begin
              inval = 1'b1;
              dr_v = 1'b1; dr = swdap_pkg::mk_done(swdap_pkg::ST_PARITY);
              phase_nxt = swdap_pkg::PH_IDLE;
            end else if (i_ack == swdap_pkg::ACK_OK) begin
              case (phase_r)
                swdap_pkg::PH_CSW_SEL, swdap_pkg::PH_TAR_SEL, swdap_pkg::PH_DRW_SEL: begin
                  sel_nxt = selv; en_go = 1'b1; en_start = phase_r;
                end
                swdap_pkg::PH_CSW: begin
                  en_go = 1'b1; en_start = swdap_pkg::PH_CSW_SEL;
                end
                swdap_pkg::PH_TAR: begin
                  en_go = 1'b1; en_start = swdap_pkg::PH_DRW_SEL;
                end
                swdap_pkg::PH_DUMMY: begin
                  en_go = 1'b1;
                  if (lacc_r == swdap_pkg::ACC_SREAD) begin
                    en_start = swdap_pkg::PH_RDBUF;
                  end else begin
                    en_start = (chunk_r <= CW'(1)) ? swdap_pkg::PH_BRDBUF : swdap_pkg::PH_BREAD;
                  end
                end
                swdap_pkg::PH_RDBUF: begin
                  dr_v = 1'b1; dr = swdap_pkg::mk_word(lane);
                  en_go = 1'b1; en_start = swdap_pkg::PH_IDLE;
                end
                swdap_pkg::PH_BREAD: begin
                  dr_v = 1'b1; dr = swdap_pkg::mk_word(i_rd);
                  chunk_nxt = chunk_r - 1'b1; words_nxt = words_r - 1'b1;
                  addr_nxt = addr_r + 32'd4;
                  en_go = 1'b1;
                  en_start = (chunk_nxt <= CW'(1)) ? swdap_pkg::PH_BRDBUF : swdap_pkg::PH_BREAD;
                end
                swdap_pkg::PH_BRDBUF: begin
                  dr_v = 1'b1; dr = swdap_pkg::mk_word(i_rd);
                  chunk_nxt = chunk_r - 1'b1; words_nxt = words_r - 1'b1;
                  addr_nxt = addr_r + 32'd4;
                  en_go = 1'b1; en_start = swdap_pkg::PH_CHUNK;
                end
                swdap_pkg::PH_SWRITE: begin
                  dr_v = 1'b1; dr = swdap_pkg::mk_done(swdap_pkg::ST_OK);
                  phase_nxt = swdap_pkg::PH_IDLE;
                end
                swdap_pkg::PH_BWRITE: begin
                  chunk_nxt = chunk_r - 1'b1; words_nxt = words_r - 1'b1;
                  addr_nxt = addr_r + 32'd4;
                  en_go = 1'b1;
                  en_start = (chunk_nxt == '0) ? swdap_pkg::PH_CTRL : swdap_pkg::PH_WORD_WAIT;
                end
                swdap_pkg::PH_CTRL: begin
                  if ((i_rd & swdap_pkg::CTRL_ERR_MASK) != 32'd0) begin
                    fstat_nxt   = swdap_pkg::ST_FAULT;
                    phase_nxt   = swdap_pkg::PH_ABORT;
                    pend_nxt    = swdap_pkg::pkt(1'b0, 1'b0, swdap_pkg::DP_ABORT,
                                                 swdap_pkg::ABORT_CLEAR);
                    retries_nxt = '0;
                    dr_v = 1'b1; dr = swdap_pkg::mk_pkt(pend_nxt);
                  end else begin
                    en_go = 1'b1; en_start = swdap_pkg::PH_CHUNK;
                  end
                end
                swdap_pkg::PH_FWRITE: begin
                  chunk_nxt = chunk_r - 1'b1; words_nxt = words_r - 1'b1;
                  addr_nxt = addr_r + 32'd4;
                  en_go = 1'b1;
                  en_start = (chunk_nxt == '0) ? swdap_pkg::PH_CHUNK : swdap_pkg::PH_FWRITE;
                end
                default: begin
                  dr_v = 1'b1; dr = swdap_pkg::mk_done(swdap_pkg::ST_PROTO);
                  phase_nxt = swdap_pkg::PH_IDLE;
                end
              endcase
            end else if (i_ack == swdap_pkg::ACK_WAIT &&
                         retry_inc < swdap_pkg::RETRY_W'(WAIT_RETRY_LIMIT)) begin
              retries_nxt = retry_inc;
              dr_v = 1'b1; dr = swdap_pkg::mk_pkt(pend_r);
            end else if (i_ack == swdap_pkg::ACK_WAIT || i_ack == swdap_pkg::ACK_FAULT) begin
              inval       = 1'b1;
              fstat_nxt   = (i_ack == swdap_pkg::ACK_WAIT) ? swdap_pkg::ST_WAIT :
                                                             swdap_pkg::ST_FAULT;
              phase_nxt   = swdap_pkg::PH_ABORT;
              pend_nxt    = swdap_pkg::pkt(1'b0, 1'b0, swdap_pkg::DP_ABORT,
                              (i_ack == swdap_pkg::ACK_WAIT) ? swdap_pkg::ABORT_DAP :
                                                               swdap_pkg::ABORT_CLEAR);
              retries_nxt = '0;
              dr_v = 1'b1; dr = swdap_pkg::mk_pkt(pend_nxt);
            end else begin
              inval = 1'b1;
              dr_v = 1'b1;
              dr = swdap_pkg::mk_done((i_ack == swdap_pkg::ACK_NONE) ? swdap_pkg::ST_NORESP :
                                                                       swdap_pkg::ST_PROTO);
              phase_nxt = swdap_pkg::PH_IDLE;
            end
            if (inval) begin
              if (phase_r == swdap_pkg::PH_CSW_SEL || phase_r == swdap_pkg::PH_CSW) begin
                csw_nxt = swdap_pkg::SHADOW_INVALID;
              end
              if (phase_r == swdap_pkg::PH_CSW_SEL || phase_r == swdap_pkg::PH_TAR_SEL ||
                  phase_r == swdap_pkg::PH_DRW_SEL) begin
                sel_nxt = swdap_pkg::SHADOW_INVALID;
              end
            end
          end
        end
        swdap_pkg::OP_INVAL: begin
          sel_nxt = swdap_pkg::SHADOW_INVALID;
          csw_nxt = swdap_pkg::SHADOW_INVALID;
        end
      endcase
    end
    // The wanted CSW and the TAR room follow the command as latched after this item.
    cswv   = (lacc_nxt <= swdap_pkg::ACC_SWRITE) ? (csw_base_r | {30'd0, lsize_nxt}) :
                                                   (csw_base_r | swdap_pkg::CSW_BLOCK_BITS);
    if (phase_r == swdap_pkg::PH_CSW && in_tuser == swdap_pkg::OP_RESP && en_go) begin
      csw_nxt = cswv;
    end
    low    = addr_nxt & (32'(TAR_WRAP_BYTES) - 32'd1);
    room32 = (32'(TAR_WRAP_BYTES) - low) >> 2;
    room   = (room32[CW-1:0] == '0) ? CW'(1) : room32[CW-1:0];
    w = swdap_pkg::walk(en_start, lacc_nxt, lsize_nxt, ldata_nxt, addr_nxt, words_nxt,
                        chunk_nxt, room, selv == sel_nxt, cswv == csw_nxt, selv, cswv);
    if (en_go) begin
      if (en_start == swdap_pkg::PH_IDLE) begin
        phase_nxt = swdap_pkg::PH_IDLE;
      end else begin
        phase_nxt = w.ph;
        chunk_nxt = w.chunk;
        if (w.act == swdap_pkg::ACT_SEND) begin
          pend_nxt    = w.pkt;
          retries_nxt = '0;
        end
      end
    end
    // A new access port number leaves both shadows stale.
    if (cfg_valid && cfg_ready && cfg_index == 1'b0 && cfg_data[7:0] != ap_index_r) begin
      sel_nxt = swdap_pkg::SHADOW_INVALID;
      csw_nxt = swdap_pkg::SHADOW_INVALID;
    end
  end

  // Engine result: a single read completion finishes directly after the word; else the walk's packet or finish.
  always_comb begin
    swdap_pkg::res_t er;
    logic            er_v;
    er   = '0;
    er_v = 1'b0;
    if (en_go && en_start == swdap_pkg::PH_IDLE) begin
      er_v = 1'b1; er = swdap_pkg::mk_done(swdap_pkg::ST_OK);
    end else if (en_go && w.act == swdap_pkg::ACT_SEND) begin
      er_v = 1'b1; er = swdap_pkg::mk_pkt(w.pkt);
    end else if (en_go && w.act == swdap_pkg::ACT_FIN) begin
      er_v = 1'b1; er = swdap_pkg::mk_done(w.status);
    end
    r0 = dr_v ? dr : er;
    r1 = er;
    push0 = dr_v || er_v;
    push1 = dr_v && er_v;
    r0.last = !push1;
    r1.last = 1'b1;
  end

  swdap_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .d0        (r0),
    .d1        (r1),
    .pop       (out_tready),
    .head      (q_head),
    .not_empty (q_ne),
    .room2     (room2)
  );

  assign out_tvalid = q_ne;
  assign out_tuser  = q_head.kind;
  assign out_tlast  = q_head.last;
  assign out_tdata  = {1'b0, q_head.status, q_head.rword, q_head.pdata, q_head.off,
                       q_head.rnw, q_head.ap};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_index_r <= '0;
      csw_base_r <= '0;
      sel_r      <= swdap_pkg::SHADOW_INVALID;
      csw_r      <= swdap_pkg::SHADOW_INVALID;
      phase_r    <= swdap_pkg::PH_IDLE;
      addr_r     <= '0;
      words_r    <= '0;
      chunk_r    <= '0;
      retries_r  <= '0;
      pend_r     <= '0;
      ldata_r    <= '0;
      lsize_r    <= '0;
      lacc_r     <= '0;
      fstat_r    <= '0;
    end else begin
      sel_r     <= sel_nxt;
      csw_r     <= csw_nxt;
      phase_r   <= phase_nxt;
      addr_r    <= addr_nxt;
      words_r   <= words_nxt;
      chunk_r   <= chunk_nxt;
      retries_r <= retries_nxt;
      pend_r    <= pend_nxt;
      ldata_r   <= ldata_nxt;
      lsize_r   <= lsize_nxt;
      lacc_r    <= lacc_nxt;
      fstat_r   <= fstat_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'b0) begin
          ap_index_r <= cfg_data[7:0];
        end else begin
          csw_base_r <= cfg_data;
        end
      end
    end
  end

  `SWDAP_ASSERT_SAME(a_retry_below_limit, clk, rst_n, 1'b1,
    retries_r < swdap_pkg::RETRY_W'(WAIT_RETRY_LIMIT))
  `SWDAP_ASSERT_SAME(a_chunk_within_words, clk, rst_n, 1'b1, {5'd0, chunk_r} <= words_r)
  `SWDAP_ASSERT_NEXT(a_cmd_gives_result, clk, rst_n,
    in_fire && in_tuser == swdap_pkg::OP_CMD && phase_r == swdap_pkg::PH_IDLE, out_tvalid)

endmodule

// ----- dv/tb_swd_mem_ap_transfer_engine_top.sv -----
// Self-checking testbench for the SWD MEM-AP transfer engine top level.
// Depends on swdap_pkg and the RTL; a built-in predictor checks every result word.
module tb_swd_mem_ap_transfer_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  acc;
    logic [1:0]  sz;
    logic [31:0] addr;
    logic [31:0] data;
    logic [15:0] cnt;
    logic [2:0]  ack;
    logic [31:0] rd;
    logic        par;
  } item_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [31:0]  cfg_data;

  swd_mem_ap_transfer_engine_top u_dut (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  item_t           item_q[$];
  swdap_pkg::res_t awaited_res[$];
  swdap_pkg::res_t step_res[$];
  int              fail_count;
  int              sent_count;
  bit              calm;

  // Predictor state.
  logic [31:0] sel_sh, csw_sh, cur_addr, pk_data, l_data, ap_reg, csw_reg;
  logic [15:0] words_left, chunk_left;
  logic [7:0]  retries;
  logic        pk_ap, pk_rnw;
  logic [1:0]  pk_off, l_size;
  logic [2:0]  l_acc, fin_st;
  swdap_pkg::phase_t ph;

  function automatic void emit(logic [1:0] kind, logic ap, logic rnw, logic [1:0] off,
                               logic [31:0] pd, logic [31:0] rw, logic [2:0] st);
    swdap_pkg::res_t r;
    r = '0;
    r.kind = kind; r.ap = ap; r.rnw = rnw; r.off = off;
    r.pdata = pd; r.rword = rw; r.status = st;
    step_res.push_back(r);
  endfunction

  function automatic void repeat_packet();
    emit(swdap_pkg::KIND_PKT, pk_ap, pk_rnw, pk_off, pk_rnw ? 32'd0 : pk_data, 32'd0,
         swdap_pkg::ST_OK);
  endfunction

  function automatic void issue(logic ap, logic rnw, logic [1:0] off, logic [31:0] d);
    pk_ap = ap; pk_rnw = rnw; pk_off = off; pk_data = d;
    retries = '0;
    repeat_packet();
  endfunction

  function automatic void close_cmd(logic [2:0] st);
    emit(swdap_pkg::KIND_DONE, 1'b0, 1'b0, 2'd0, 32'd0, 32'd0, st);
    ph = swdap_pkg::PH_IDLE;
  endfunction

  function automatic logic [31:0] select_value();
    return {ap_reg[7:0], 24'd0};
  endfunction

  function automatic logic [31:0] csw_value();
    if (l_acc <= swdap_pkg::ACC_SWRITE) return csw_reg | {30'd0, l_size};
    return csw_reg | swdap_pkg::CSW_BLOCK_BITS;
  endfunction

  function automatic void advance(swdap_pkg::phase_t target);
    swdap_pkg::phase_t p;
    bit                go;
    logic [31:0]       d, room;
    p = target;
    go = 1'b1;
    while (go) begin
      ph = p;
      go = 1'b0;
      case (p)
        swdap_pkg::PH_CSW_SEL: begin
          if (csw_value() == csw_sh) begin
            p = (l_acc == swdap_pkg::ACC_FILL) ? swdap_pkg::PH_CHUNK : swdap_pkg::PH_TAR_SEL;
            go = 1'b1;
          end else if (select_value() == sel_sh) begin
            p = swdap_pkg::PH_CSW; go = 1'b1;
          end else issue(1'b0, 1'b0, swdap_pkg::DP_SELECT, select_value());
        end
        swdap_pkg::PH_CSW: issue(1'b1, 1'b0, swdap_pkg::AP_CSW, csw_value());
        swdap_pkg::PH_TAR_SEL: begin
          if (select_value() == sel_sh) begin
            p = swdap_pkg::PH_TAR; go = 1'b1;
          end else issue(1'b0, 1'b0, swdap_pkg::DP_SELECT, select_value());
        end
        swdap_pkg::PH_TAR: issue(1'b1, 1'b0, swdap_pkg::AP_TAR, cur_addr);
        swdap_pkg::PH_DRW_SEL: begin
          if (select_value() != sel_sh) issue(1'b0, 1'b0, swdap_pkg::DP_SELECT, select_value());
          else begin
            go = 1'b1;
            if (l_acc == swdap_pkg::ACC_SREAD || l_acc == swdap_pkg::ACC_BREAD)
              p = swdap_pkg::PH_DUMMY;
            else if (l_acc == swdap_pkg::ACC_SWRITE) p = swdap_pkg::PH_SWRITE;
            else if (l_acc == swdap_pkg::ACC_BWRITE) p = swdap_pkg::PH_WORD_WAIT;
            else p = swdap_pkg::PH_FWRITE;
          end
        end
        swdap_pkg::PH_DUMMY, swdap_pkg::PH_BREAD:
          issue(1'b1, 1'b1, swdap_pkg::AP_DRW, 32'd0);
        swdap_pkg::PH_RDBUF, swdap_pkg::PH_BRDBUF:
          issue(1'b0, 1'b1, swdap_pkg::DP_RDBUFF, 32'd0);
        swdap_pkg::PH_SWRITE: begin
          d = l_data;
          if (l_size == swdap_pkg::SZ_BYTE) d = (l_data & 32'hFF) << (cur_addr[1:0] * 8);
          else if (l_size == swdap_pkg::SZ_HALF) d = (l_data & 32'hFFFF) << (cur_addr[1] * 16);
          issue(1'b1, 1'b0, swdap_pkg::AP_DRW, d);
        end
        swdap_pkg::PH_WORD_WAIT: ;
        swdap_pkg::PH_CTRL: issue(1'b0, 1'b1, swdap_pkg::DP_CTRL, 32'd0);
        swdap_pkg::PH_FWRITE: issue(1'b1, 1'b0, swdap_pkg::AP_DRW, l_data);
        swdap_pkg::PH_CHUNK: begin
          if (words_left == 0) close_cmd(swdap_pkg::ST_OK);
          else begin
            room = (swdap_pkg::TAR_WRAP_BYTES -
                    (cur_addr & (swdap_pkg::TAR_WRAP_BYTES - 1))) / 4;
            if (room == 0) room = 1;
            chunk_left = (words_left < room) ? words_left : room[15:0];
            p = (l_acc == swdap_pkg::ACC_FILL) ? swdap_pkg::PH_TAR_SEL : swdap_pkg::PH_CSW_SEL;
            go = 1'b1;
          end
        end
        default: close_cmd(swdap_pkg::ST_PROTO);
      endcase
    end
  endfunction

  function automatic void word_moved();
    chunk_left--;
    words_left--;
    cur_addr += 32'd4;
  endfunction

  function automatic void drop_shadows_on_error();
    if (ph == swdap_pkg::PH_CSW_SEL || ph == swdap_pkg::PH_CSW)
      csw_sh = swdap_pkg::SHADOW_INVALID;
    if (ph == swdap_pkg::PH_CSW_SEL || ph == swdap_pkg::PH_TAR_SEL ||
        ph == swdap_pkg::PH_DRW_SEL)
      sel_sh = swdap_pkg::SHADOW_INVALID;
  endfunction

  function automatic void ack_ok(logic [31:0] rd);
    logic [31:0] v;
    case (ph)
      swdap_pkg::PH_CSW_SEL, swdap_pkg::PH_TAR_SEL, swdap_pkg::PH_DRW_SEL: begin
        sel_sh = select_value(); advance(ph);
      end
      swdap_pkg::PH_CSW: begin
        csw_sh = csw_value(); advance(swdap_pkg::PH_CSW_SEL);
      end
      swdap_pkg::PH_TAR: advance(swdap_pkg::PH_DRW_SEL);
      swdap_pkg::PH_DUMMY: begin
        if (l_acc == swdap_pkg::ACC_SREAD) advance(swdap_pkg::PH_RDBUF);
        else advance(chunk_left <= 1 ? swdap_pkg::PH_BRDBUF : swdap_pkg::PH_BREAD);
      end
      swdap_pkg::PH_RDBUF: begin
        v = rd;
        if (l_size == swdap_pkg::SZ_BYTE) v = (rd >> (cur_addr[1:0] * 8)) & 32'hFF;
        else if (l_size == swdap_pkg::SZ_HALF) v = (rd >> (cur_addr[1] * 16)) & 32'hFFFF;
        emit(swdap_pkg::KIND_WORD, 1'b0, 1'b0, 2'd0, 32'd0, v, swdap_pkg::ST_OK);
        close_cmd(swdap_pkg::ST_OK);
      end
      swdap_pkg::PH_BREAD: begin
        emit(swdap_pkg::KIND_WORD, 1'b0, 1'b0, 2'd0, 32'd0, rd, swdap_pkg::ST_OK);
        word_moved();
        advance(chunk_left <= 1 ? swdap_pkg::PH_BRDBUF : swdap_pkg::PH_BREAD);
      end
      swdap_pkg::PH_BRDBUF: begin
        emit(swdap_pkg::KIND_WORD, 1'b0, 1'b0, 2'd0, 32'd0, rd, swdap_pkg::ST_OK);
        word_moved();
        advance(swdap_pkg::PH_CHUNK);
      end
      swdap_pkg::PH_SWRITE: close_cmd(swdap_pkg::ST_OK);
      swdap_pkg::PH_BWRITE: begin
        word_moved();
        advance(chunk_left == 0 ? swdap_pkg::PH_CTRL : swdap_pkg::PH_WORD_WAIT);
      end
      swdap_pkg::PH_CTRL: begin
        if ((rd & swdap_pkg::CTRL_ERR_MASK) != 0) begin
          fin_st = swdap_pkg::ST_FAULT; ph = swdap_pkg::PH_ABORT;
          issue(1'b0, 1'b0, swdap_pkg::DP_ABORT, swdap_pkg::ABORT_CLEAR);
        end else advance(swdap_pkg::PH_CHUNK);
      end
      swdap_pkg::PH_FWRITE: begin
        word_moved();
        advance(chunk_left == 0 ? swdap_pkg::PH_CHUNK : swdap_pkg::PH_FWRITE);
      end
      default: close_cmd(swdap_pkg::ST_PROTO);
    endcase
  endfunction

  function automatic void packet_ack(logic [2:0] ack, logic [31:0] rd, logic par);
    if (ph == swdap_pkg::PH_ABORT) begin
      close_cmd(fin_st);
      return;
    end
    if (ack == swdap_pkg::ACK_OK) begin
      if (pk_rnw && !par) begin
        drop_shadows_on_error(); close_cmd(swdap_pkg::ST_PARITY);
      end else ack_ok(rd);
      return;
    end
    if (ack == swdap_pkg::ACK_WAIT) begin
      retries++;
      if (retries < swdap_pkg::WAIT_RETRY_LIMIT) repeat_packet();
      else begin
        drop_shadows_on_error();
        fin_st = swdap_pkg::ST_WAIT; ph = swdap_pkg::PH_ABORT;
        issue(1'b0, 1'b0, swdap_pkg::DP_ABORT, swdap_pkg::ABORT_DAP);
      end
      return;
    end
    drop_shadows_on_error();
    if (ack == swdap_pkg::ACK_FAULT) begin
      fin_st = swdap_pkg::ST_FAULT; ph = swdap_pkg::PH_ABORT;
      issue(1'b0, 1'b0, swdap_pkg::DP_ABORT, swdap_pkg::ABORT_CLEAR);
    end else close_cmd(ack == swdap_pkg::ACK_NONE ? swdap_pkg::ST_NORESP : swdap_pkg::ST_PROTO);
  endfunction

  function automatic void start_cmd(item_t it);
    l_data = it.data; l_size = it.sz; l_acc = it.acc;
    cur_addr = it.addr; words_left = it.cnt; chunk_left = '0;
    if (it.acc > swdap_pkg::ACC_FILL ||
        (it.acc <= swdap_pkg::ACC_SWRITE && it.sz == swdap_pkg::SZ_BAD))
      close_cmd(swdap_pkg::ST_PROTO);
    else if (it.acc <= swdap_pkg::ACC_SWRITE) advance(swdap_pkg::PH_CSW_SEL);
    else if (it.addr[1:0] != 2'd0) close_cmd(swdap_pkg::ST_PROTO);
    else if (it.acc == swdap_pkg::ACC_FILL) advance(swdap_pkg::PH_CSW_SEL);
    else advance(swdap_pkg::PH_CHUNK);
  endfunction

  function automatic void engine_step(item_t it);
    swdap_pkg::res_t r;
    step_res.delete();
    case (it.op)
      swdap_pkg::OP_CMD: if (ph == swdap_pkg::PH_IDLE) start_cmd(it);
      swdap_pkg::OP_WORD: begin
        if (ph == swdap_pkg::PH_WORD_WAIT) begin
          ph = swdap_pkg::PH_BWRITE; issue(1'b1, 1'b0, swdap_pkg::AP_DRW, it.data);
        end
      end
      swdap_pkg::OP_RESP:
        if (ph != swdap_pkg::PH_IDLE && ph != swdap_pkg::PH_WORD_WAIT)
          packet_ack(it.ack, it.rd, it.par);
      default: begin
        sel_sh = swdap_pkg::SHADOW_INVALID; csw_sh = swdap_pkg::SHADOW_INVALID;
      end
    endcase
    foreach (step_res[i]) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      awaited_res.push_back(r);
    end
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.op = 2'($urandom_range(0, 3)); it.acc = 3'($urandom_range(0, 7));
    it.sz = 2'($urandom_range(0, 3));
    it.addr = $urandom; it.data = $urandom; it.cnt = 16'($urandom);
    it.ack = 3'($urandom_range(0, 7)); it.rd = $urandom; it.par = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void queue_item(item_t it);
    engine_step(it);
    item_q.push_back(it);
  endfunction

  // Answers every packet of the current command; ack_mix 0 gives only OK.
  function automatic void answer_until_idle(int ack_mix);
    item_t it;
    int    pick;
    while (ph != swdap_pkg::PH_IDLE) begin
      it = random_item();
      if (ph == swdap_pkg::PH_WORD_WAIT) it.op = swdap_pkg::OP_WORD;
      else begin
        it.op = swdap_pkg::OP_RESP;
        it.ack = swdap_pkg::ACK_OK;
        it.par = 1'b1;
        if (ph == swdap_pkg::PH_CTRL && $urandom_range(0, 5) != 0)
          it.rd &= ~swdap_pkg::CTRL_ERR_MASK;
        if (ack_mix != 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 5) it.ack = swdap_pkg::ACK_WAIT;
          else if (pick < 8) it.ack = swdap_pkg::ACK_FAULT;
          else if (pick < 10) it.ack = swdap_pkg::ACK_NONE;
          else if (pick < 12) it.ack = 3'd3 + 3'($urandom_range(0, 1)) * 3'd3;
          else if (pick < 14) it.par = 1'b0;
        end
      end
      if (ack_mix != 0 && $urandom_range(0, 15) == 0) queue_item(random_item());
      queue_item(it);
      sent_count++;
    end
  endfunction

  function automatic void command(logic [2:0] acc, logic [1:0] sz, logic [31:0] addr,
                                  logic [15:0] cnt, int ack_mix);
    item_t it;
    it = random_item();
    it.op = swdap_pkg::OP_CMD; it.acc = acc; it.sz = sz; it.addr = addr; it.cnt = cnt;
    queue_item(it);
    sent_count++;
    answer_until_idle(ack_mix);
  endfunction

  task automatic drain();
    while (item_q.size() != 0 || in_tvalid || awaited_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == 1'b0) begin
      if (val[7:0] != ap_reg[7:0]) begin
        ap_reg = {24'd0, val[7:0]};
        sel_sh = swdap_pkg::SHADOW_INVALID; csw_sh = swdap_pkg::SHADOW_INVALID;
      end
    end else csw_reg = val;
    @(posedge clk);
  endtask

  // Driver: one word per handshake, with random gaps between words unless calm is set.
  int gap;
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 1'b0;
      end else if (item_q.size() != 0) begin
        it = item_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.op;
        in_tdata <= {7'd0, it.par, it.rd, it.ack, it.cnt, it.data, it.addr, it.sz, it.acc};
        if (!calm && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 18);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  int stall;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall <= 0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 11) == 0) stall <= $urandom_range(1, 18);
    end
  end

  // Monitor and watchdog.
  int idle_cycles;
  always @(posedge clk) begin
    swdap_pkg::res_t w;
    swdap_pkg::res_t got;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = '0;
        got.kind = out_tuser; got.ap = out_tdata[0]; got.rnw = out_tdata[1];
        got.off = out_tdata[3:2]; got.pdata = out_tdata[35:4];
        got.rword = out_tdata[67:36]; got.status = out_tdata[70:68]; got.last = out_tlast;
        if (awaited_res.size() == 0) begin
          $error("unexpected result word, kind %0d", got.kind);
          fail_count++;
        end else begin
          w = awaited_res.pop_front();
          if (got.kind !== w.kind) begin
            $error("kind: expected %0d, got %0d", w.kind, got.kind); fail_count++;
          end
          if (got.ap !== w.ap) begin
            $error("ap_not_dp: expected %0d, got %0d", w.ap, got.ap); fail_count++;
          end
          if (got.rnw !== w.rnw) begin
            $error("read_not_write: expected %0d, got %0d", w.rnw, got.rnw); fail_count++;
          end
          if (got.off !== w.off) begin
            $error("reg_offset: expected %0d, got %0d", w.off, got.off); fail_count++;
          end
          if (got.pdata !== w.pdata) begin
            $error("packet_data: expected %h, got %h", w.pdata, got.pdata); fail_count++;
          end
          if (got.rword !== w.rword) begin
            $error("read_word: expected %h, got %h", w.rword, got.rword); fail_count++;
          end
          if (got.status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, got.status); fail_count++;
          end
          if (got.last !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, got.last); fail_count++;
          end
        end
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    item_t       it;
    logic [31:0] a;
    logic [2:0]  acc;
    logic [15:0] n;
    fail_count = 0; sent_count = 0; calm = 1'b0;
    ap_reg = '0; csw_reg = '0;
    sel_sh = swdap_pkg::SHADOW_INVALID; csw_sh = swdap_pkg::SHADOW_INVALID;
    ph = swdap_pkg::PH_IDLE; cur_addr = '0; words_left = '0; chunk_left = '0; retries = '0;
    pk_ap = 1'b0; pk_rnw = 1'b0; pk_off = '0; pk_data = '0;
    l_data = '0; l_size = '0; l_acc = '0; fin_st = '0;
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(1'b0, 32'h0000_00A5);
    write_reg(1'b1, 32'h2300_0040);

    // Directed: each access kind, lanes, special cases and error acks.
    it = random_item(); it.op = swdap_pkg::OP_RESP; queue_item(it);
    it = random_item(); it.op = swdap_pkg::OP_WORD; queue_item(it);
    command(swdap_pkg::ACC_SREAD, swdap_pkg::SZ_BYTE, 32'h2000_0003, 16'd0, 0);
    command(swdap_pkg::ACC_SREAD, swdap_pkg::SZ_HALF, 32'h2000_0002, 16'd0, 0);
    command(swdap_pkg::ACC_SWRITE, swdap_pkg::SZ_BYTE, 32'h2000_0001, 16'd0, 0);
    command(swdap_pkg::ACC_SWRITE, 2'd2, 32'hFFFF_FFFC, 16'd0, 0);
    command(swdap_pkg::ACC_BREAD, 2'd2, 32'h2000_03F8, 16'd4, 0);
    command(swdap_pkg::ACC_BWRITE, 2'd2, 32'h2000_03FC, 16'd3, 0);
    command(swdap_pkg::ACC_FILL, 2'd2, 32'h0000_0000, 16'd2, 0);
    command(swdap_pkg::ACC_FILL, 2'd2, 32'h0000_0010, 16'd0, 0);
    command(swdap_pkg::ACC_BREAD, 2'd2, 32'h0000_0010, 16'd0, 0);
    command(3'd7, 2'd2, 32'h0, 16'd1, 0);
    command(swdap_pkg::ACC_SREAD, swdap_pkg::SZ_BAD, 32'h0, 16'd1, 0);
    command(swdap_pkg::ACC_BWRITE, 2'd2, 32'h0000_0002, 16'd1, 0);
    it = random_item(); it.op = swdap_pkg::OP_INVAL; queue_item(it);
    it = random_item(); it.op = swdap_pkg::OP_CMD; it.acc = swdap_pkg::ACC_SREAD;
    it.sz = swdap_pkg::SZ_BYTE; queue_item(it);
    queue_item(it);
    it.op = swdap_pkg::OP_RESP; it.ack = swdap_pkg::ACK_OK; it.par = 1'b0; queue_item(it);
    it = random_item(); it.op = swdap_pkg::OP_CMD; it.acc = swdap_pkg::ACC_SWRITE;
    it.sz = swdap_pkg::SZ_HALF; queue_item(it);
    it.op = swdap_pkg::OP_RESP; it.ack = swdap_pkg::ACK_FAULT; queue_item(it);
    it.ack = swdap_pkg::ACK_OK; queue_item(it);
    it.op = swdap_pkg::OP_CMD; it.acc = swdap_pkg::ACC_SREAD; it.sz = swdap_pkg::SZ_HALF;
    queue_item(it);
    it.op = swdap_pkg::OP_RESP; it.ack = swdap_pkg::ACK_NONE; queue_item(it);
    it.op = swdap_pkg::OP_CMD; queue_item(it);
    it.op = swdap_pkg::OP_RESP; it.ack = 3'd0; queue_item(it);
    it.op = swdap_pkg::OP_CMD; queue_item(it);
    it.op = swdap_pkg::OP_RESP; it.ack = swdap_pkg::ACK_WAIT;
    repeat (swdap_pkg::WAIT_RETRY_LIMIT) queue_item(it);
    it.ack = swdap_pkg::ACK_OK; queue_item(it);
    drain();

    // Random phases over several register settings, extremes first.
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin write_reg(1'b0, 32'h0); write_reg(1'b1, 32'h0); end
        1: begin write_reg(1'b0, 32'hFF); write_reg(1'b1, 32'hFFFF_FFFF); end
        default: begin write_reg(1'b0, $urandom); write_reg(1'b1, $urandom); end
      endcase
      if (phase_no == 3) calm = 1'b1;
      sent_count = 0;
      while (sent_count < 50) begin
        acc = 3'($urandom_range(0, 4));
        if ($urandom_range(0, 30) == 0) acc = 3'($urandom_range(5, 7));
        a = $urandom;
        if (acc >= swdap_pkg::ACC_BREAD && $urandom_range(0, 9) != 0) a[1:0] = 2'd0;
        if ($urandom_range(0, 3) == 0) a[9:0] = 10'h3F0 | (a[9:0] & 10'h00F);
        n = 16'($urandom_range(1, 6));
        if ($urandom_range(0, 15) == 0) n = 16'd0;
        else if ($urandom_range(0, 40) == 0) n = 16'($urandom_range(20, 40));
        command(acc, ($urandom_range(0, 30) == 0) ? swdap_pkg::SZ_BAD :
                                                     2'($urandom_range(0, 2)),
                a, n, 1);
        if ($urandom_range(0, 10) == 0) begin
          it = random_item();
          it.cnt = 16'($urandom_range(0, 6));
          queue_item(it);
        end
      end
      answer_until_idle(0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (awaited_res.size() != 0) begin
      $error("%0d expected result words never arrived", awaited_res.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
